// ===== rtl/pifm_pkg.sv =====
// Shared types and constants of the peak interval frequency meter.
`timescale 1ns / 1ps

package pifm_pkg;

    // Capture geometry
    localparam int CAPTURE_DEPTH = 256;
    localparam int SAMPLE_W      = 12;
    localparam int IDX_W         = $clog2(CAPTURE_DEPTH);

    // Result arithmetic
    localparam int NUM_W        = 24;
    localparam int CNT_W        = $clog2(NUM_W + 1);
    localparam int PEAKS_W      = 3;
    localparam int PEAKS_NEEDED = 4;
    localparam logic [NUM_W-1:0] RATE_RESET = NUM_W'(32000);

    // Stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Job handed from the front end to the divider
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] span;
    } pifm_job_t;

    // Divider sequencer states
    typedef enum logic {
        BACK_IDLE,
        BACK_DIV
    } pifm_back_state_t;

endpackage

// ===== rtl/pifm_front.sv =====
// Front end: tracks sample history, finds peaks and posts one job per capture.
`timescale 1ns / 1ps

module pifm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [pifm_pkg::SAMPLE_W-1:0] sample,
    input  logic                          first_of_capture,
    input  logic                          last_of_capture,
    output logic                          job_push,
    output pifm_pkg::pifm_job_t           job
);

    logic [pifm_pkg::SAMPLE_W-1:0] older_reg, older_next;
    logic [pifm_pkg::SAMPLE_W-1:0] newer_reg, newer_next;
    logic [1:0]                    fill_reg, fill_next;
    logic [pifm_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [pifm_pkg::PEAKS_W-1:0]  peaks_reg, peaks_next;
    logic [pifm_pkg::IDX_W-1:0]    fpos_reg, fpos_next;
    logic                          done_reg, done_next;

    // Effective state after an optional restart
    logic [pifm_pkg::SAMPLE_W-1:0] older_eff, newer_eff;
    logic [1:0]                    fill_eff;
    logic [pifm_pkg::IDX_W-1:0]    idx_eff, fpos_eff, pos;
    logic [pifm_pkg::PEAKS_W-1:0]  peaks_eff, peaks_inc;
    logic                          done_eff, is_peak;

    always_comb begin
        older_eff = first_of_capture ? '0 : older_reg;
        newer_eff = first_of_capture ? '0 : newer_reg;
        fill_eff  = first_of_capture ? '0 : fill_reg;
        idx_eff   = first_of_capture ? '0 : idx_reg;
        peaks_eff = first_of_capture ? '0 : peaks_reg;
        fpos_eff  = first_of_capture ? '0 : fpos_reg;
        done_eff  = first_of_capture ? 1'b0 : done_reg;

        is_peak   = (fill_eff >= 2'd2) && (older_eff < newer_eff) && (newer_eff > sample);
        pos       = idx_eff - pifm_pkg::IDX_W'(1);
        peaks_inc = peaks_eff + pifm_pkg::PEAKS_W'(1);

        older_next = older_eff;
        newer_next = newer_eff;
        fill_next  = fill_eff;
        idx_next   = idx_eff;
        peaks_next = peaks_eff;
        fpos_next  = fpos_eff;
        done_next  = done_eff;
        job_push   = 1'b0;
        job.found  = 1'b0;
        job.span   = '0;

        if (!done_eff) begin
            if (is_peak) begin
                peaks_next = peaks_inc;
                if (peaks_inc == pifm_pkg::PEAKS_W'(1)) begin
                    fpos_next = pos;
                end
            end
            if (is_peak && (peaks_inc >= pifm_pkg::PEAKS_W'(pifm_pkg::PEAKS_NEEDED))) begin
                // fourth peak: hand the span to the divider, skip the rest
                job_push  = accept;
                job.found = 1'b1;
                job.span  = pos - fpos_eff;
                done_next = 1'b1;
            end else begin
                older_next = newer_eff;
                newer_next = sample;
                if (fill_eff < 2'd2) begin
                    fill_next = fill_eff + 2'd1;
                end
                if (last_of_capture ||
                    (idx_eff == pifm_pkg::IDX_W'(pifm_pkg::CAPTURE_DEPTH - 1))) begin
                    // capture ended short of four peaks
                    job_push  = accept;
                    done_next = 1'b1;
                end else begin
                    idx_next = idx_eff + pifm_pkg::IDX_W'(1);
                end
            end
        end
    end

    // Measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg <= '0;
            newer_reg <= '0;
            fill_reg  <= '0;
            idx_reg   <= '0;
            peaks_reg <= '0;
            fpos_reg  <= '0;
            done_reg  <= 1'b0;
        end else if (accept) begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            peaks_reg <= peaks_next;
            fpos_reg  <= fpos_next;
            done_reg  <= done_next;
        end
    end

endmodule

// ===== rtl/pifm_queue.sv =====
// Two-entry job queue between the front end and the divider.
`timescale 1ns / 1ps

module pifm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pifm_pkg::pifm_job_t push_job,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output pifm_pkg::pifm_job_t head_job
);

    pifm_pkg::pifm_job_t entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/pifm_back.sv =====
// Back end: numerator register, bit-serial divider and output register.
`timescale 1ns / 1ps

module pifm_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [pifm_pkg::NUM_W-1:0] cfg_wdata,
    input  logic                       job_valid,
    input  pifm_pkg::pifm_job_t        job,
    output logic                       job_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [pifm_pkg::NUM_W-1:0] out_frequency,
    output logic                       out_found
);

    logic [pifm_pkg::NUM_W-1:0] rate_numerator_reg;

    pifm_pkg::pifm_back_state_t state_reg, state_next;
    logic [pifm_pkg::NUM_W-1:0] quot_reg, quot_next;
    logic [pifm_pkg::IDX_W-1:0] rem_reg, rem_next;
    logic [pifm_pkg::IDX_W-1:0] div_reg, div_next;
    logic [pifm_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       found_reg, found_next;

    logic                       out_valid_reg, out_valid_next;
    logic [pifm_pkg::NUM_W-1:0] out_freq_reg, out_freq_next;
    logic                       out_found_reg, out_found_next;

    logic [pifm_pkg::IDX_W:0]   rem_shift, rem_diff;
    logic                       out_free;

    assign out_valid     = out_valid_reg;
    assign out_frequency = out_freq_reg;
    assign out_found     = out_found_reg;

    // Scale register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_numerator_reg <= pifm_pkg::RATE_RESET;
        end else if (cfg_we) begin
            rate_numerator_reg <= cfg_wdata;
        end
    end

    // Restoring division, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg, quot_reg[pifm_pkg::NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        out_free  = !out_valid_reg || out_ready;

        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_freq_next  = out_freq_reg;
        out_found_next = out_found_reg;
        job_pop        = 1'b0;

        case (state_reg)
            pifm_pkg::BACK_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    found_next = job.found;
                    div_next   = job.span;
                    rem_next   = '0;
                    quot_next  = job.found ? rate_numerator_reg : '0;
                    cnt_next   = job.found ? pifm_pkg::CNT_W'(pifm_pkg::NUM_W) : '0;
                    state_next = pifm_pkg::BACK_DIV;
                end
            end
            pifm_pkg::BACK_DIV: begin
                if (cnt_reg != '0) begin
                    cnt_next = cnt_reg - pifm_pkg::CNT_W'(1);
                    if (!rem_diff[pifm_pkg::IDX_W]) begin
                        rem_next  = rem_diff[pifm_pkg::IDX_W-1:0];
                        quot_next = {quot_reg[pifm_pkg::NUM_W-2:0], 1'b1};
                    end else begin
                        rem_next  = rem_shift[pifm_pkg::IDX_W-1:0];
                        quot_next = {quot_reg[pifm_pkg::NUM_W-2:0], 1'b0};
                    end
                end else if (out_free) begin
                    // quotient ready: move it to the output register
                    out_valid_next = 1'b1;
                    out_freq_next  = quot_reg;
                    out_found_next = found_reg;
                    state_next     = pifm_pkg::BACK_IDLE;
                end
            end
            default: begin
                state_next = pifm_pkg::BACK_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pifm_pkg::BACK_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        div_reg       <= div_next;
        found_reg     <= found_next;
        out_freq_reg  <= out_freq_next;
        out_found_reg <= out_found_next;
    end

endmodule

// ===== rtl/peak_interval_frequency_meter_top.sv =====
// Peak interval frequency meter: streams capture samples, returns one frequency per capture.
//
// Input stream (s_*): one 12-bit ADC sample per item in s_tdata; s_tuser marks the
// first sample of a capture (restarts the measurement), s_tlast the last one.
// Output stream (m_*): one item per capture: m_tdata holds rate_numerator / span
// between first and fourth peak, m_tuser is 1 when four peaks were found; a capture
// that ends first gives m_tuser = 0 and a zero frequency. Later samples of a capture
// that already produced its result give nothing.
// Configuration: cfg_we with cfg_wdata writes rate_numerator; the user must do this only
// while the block is idle, the block itself does not enforce it. Throughput: one sample per
// cycle while the two-entry job queue has room. A found result holds the divider for the
// pop, the 24 quotient bits and the output load, a capture without four peaks only for
// the pop and the output load, so short captures back up into the queue, dropping s_tready.
// Result path: with an idle divider, the job of the deciding sample passes the queue, the
// pop, the quotient bits when found and the output load before m_tvalid rises.
// Reset (aresetn low, synchronous): clears the measurement, empties the queue, drops
// m_tvalid and sets rate_numerator to 32000.
// When m_tready is low the result is held; the divider finishes the next job and
// waits, and the front end keeps taking samples until the queue is full.
`timescale 1ns / 1ps

module peak_interval_frequency_meter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [pifm_pkg::NUM_W-1:0]        cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pifm_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample, rest zero
    input  logic                              s_tuser,   // [0] first_of_capture
    input  logic                              s_tlast,   // last_of_capture
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pifm_pkg::M_TDATA_W-1:0]    m_tdata,   // [23:0] frequency, rest zero
    output logic                              m_tuser    // [0] found
);

    logic                       accept, q_full, q_not_empty, push, pop;
    pifm_pkg::pifm_job_t        push_job, head_job;
    logic [pifm_pkg::NUM_W-1:0] frequency;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    pifm_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .sample           (s_tdata[pifm_pkg::SAMPLE_W-1:0]),
        .first_of_capture (s_tuser),
        .last_of_capture  (s_tlast),
        .job_push         (push),
        .job              (push_job)
    );

    pifm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_job  (head_job)
    );

    pifm_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .job_valid     (q_not_empty),
        .job           (head_job),
        .job_pop       (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_frequency (frequency),
        .out_found     (m_tuser)
    );

    // Pad the frequency to the 32-bit m_tdata width
    assign m_tdata = {{(pifm_pkg::M_TDATA_W - pifm_pkg::NUM_W){1'b0}}, frequency};

endmodule

// ===== rtl/pifm_checker.sv =====
// Port-level checks of the peak interval frequency meter, bound to the top level.
`timescale 1ns / 1ps

module pifm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pifm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);

    // Reset drops the result channel
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A capture without four peaks reports zero
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("nonzero frequency without found");

    // Stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // Stalled result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind peak_interval_frequency_meter_top pifm_checker u_pifm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/tb_peak_interval_frequency_meter_top.sv =====
// Self-checking testbench for the peak interval frequency meter stream block.
`timescale 1ns / 1ps

module tb_peak_interval_frequency_meter_top;

    localparam int LAST_IDX     = pifm_pkg::CAPTURE_DEPTH - 1;
    localparam int SAMPLE_MAX   = (1 << pifm_pkg::SAMPLE_W) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 300;
    localparam int PHASE_CAPS   = 6;
    localparam int RAMP_LEN     = pifm_pkg::CAPTURE_DEPTH + 4;

    typedef struct packed {
        logic [pifm_pkg::SAMPLE_W-1:0] sample;
        logic                          first;
        logic                          last;
    } adc_item_t;

    typedef struct packed {
        logic [pifm_pkg::NUM_W-1:0] frequency;
        logic                       found;
    } freq_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [pifm_pkg::NUM_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic [pifm_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tready  = 1'b0;
    logic                            s_tready;
    logic                            m_tvalid;
    logic [pifm_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;

    // Pending items and expected frequencies
    adc_item_t    sample_feed_q[$];
    freq_result_t freq_expect_q[$];

    // Predictor state
    logic [pifm_pkg::NUM_W-1:0]    rate_num       = pifm_pkg::RATE_RESET;
    logic [pifm_pkg::SAMPLE_W-1:0] prev2_smp      = '0;
    logic [pifm_pkg::SAMPLE_W-1:0] prev1_smp      = '0;
    logic [1:0]                    hist_cnt       = '0;
    logic [pifm_pkg::IDX_W-1:0]    smp_idx        = '0;
    logic [pifm_pkg::PEAKS_W-1:0]  peak_cnt       = '0;
    logic [pifm_pkg::IDX_W-1:0]    first_peak_idx = '0;
    logic                          meas_done      = 1'b0;

    adc_item_t    drv_item;
    freq_result_t got_exp;
    bit           idle_on   = 1'b1;
    int           send_gap  = 0;
    int           sink_gap  = 0;
    int           err_cnt   = 0;
    int           cycle_cnt = 0;
    int           ramp_cnt  = 0;

    peak_interval_frequency_meter_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [11:0] sample, rest zero
        .s_tuser   (s_tuser),   // [0] first_of_capture
        .s_tlast   (s_tlast),   // last_of_capture
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [23:0] frequency, rest zero
        .m_tuser   (m_tuser)    // [0] found
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Peak tracker: advances on each accepted item, queues the frequency it causes
    task automatic track_peaks(input adc_item_t it);
        logic [pifm_pkg::IDX_W-1:0] pos;
        logic [pifm_pkg::IDX_W-1:0] span;
        freq_result_t               res;
        if (it.first) begin
            prev2_smp      = '0;
            prev1_smp      = '0;
            hist_cnt       = '0;
            smp_idx        = '0;
            peak_cnt       = '0;
            first_peak_idx = '0;
            meas_done      = 1'b0;
        end
        if (meas_done)
            return;
        // strict local maximum at the previous index
        if (hist_cnt == 2'd2 && prev2_smp < prev1_smp && prev1_smp > it.sample) begin
            pos      = smp_idx - 1'b1;
            peak_cnt = peak_cnt + 1'b1;
            if (peak_cnt == 1)
                first_peak_idx = pos;
            if (peak_cnt >= pifm_pkg::PEAKS_NEEDED) begin
                span          = pos - first_peak_idx;
                res.frequency = rate_num / span;
                res.found     = 1'b1;
                freq_expect_q.push_back(res);
                meas_done = 1'b1;
                return;
            end
        end
        prev2_smp = prev1_smp;
        prev1_smp = it.sample;
        if (hist_cnt < 2'd2)
            hist_cnt = hist_cnt + 1'b1;
        // capture ended short of four peaks; memory end counts as last
        if (it.last || smp_idx == LAST_IDX) begin
            res.frequency = '0;
            res.found     = 1'b0;
            freq_expect_q.push_back(res);
            meas_done = 1'b1;
            return;
        end
        smp_idx = smp_idx + 1'b1;
    endtask

    // Sender: drives queued items, with random gaps between them while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_peaks(drv_item);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (sample_feed_q.size() > 0) begin
                    drv_item = sample_feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= pifm_pkg::S_TDATA_W'(drv_item.sample);
                    s_tuser  <= drv_item.first;
                    s_tlast  <= drv_item.last;
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 4);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest expectation, stalls at random while idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (freq_expect_q.size() == 0) begin
                    $display("%0t: unexpected result: frequency=%0d found=%0b",
                             $time, m_tdata[pifm_pkg::NUM_W-1:0], m_tuser);
                    err_cnt++;
                end else begin
                    got_exp = freq_expect_q.pop_front();
                    if (m_tdata[pifm_pkg::NUM_W-1:0] !== got_exp.frequency) begin
                        $display("%0t: frequency mismatch: expected %0d, actual %0d",
                                 $time, got_exp.frequency, m_tdata[pifm_pkg::NUM_W-1:0]);
                        err_cnt++;
                    end
                    if (m_tuser !== got_exp.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, got_exp.found, m_tuser);
                        err_cnt++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 4);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, freq_expect_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic push_item(input int smp, input bit first, input bit last);
        adc_item_t it;
        it.sample = smp[pifm_pkg::SAMPLE_W-1:0];
        it.first  = first;
        it.last   = last;
        sample_feed_q.push_back(it);
    endtask

    // Triangle wave; odd periods give a flat top, which is no peak
    task automatic push_wave(input int len, input int period, input int step, input int base,
                             input int noise, input bit first, input bit last);
        int half;
        int ph;
        int v;
        half = period / 2;
        for (int k = 0; k < len; k++) begin
            ph = k % period;
            v  = base + ((ph <= half) ? ph : period - ph) * step;
            if (noise > 0)
                v += $urandom_range(0, noise);
            if (v > SAMPLE_MAX)
                v = SAMPLE_MAX;
            push_item(v, first && k == 0, last && k == len - 1);
        end
    endtask

    // Wait until every item is accepted and every result has arrived, then settle
    task automatic wait_drained();
        @(negedge aclk);
        while (sample_feed_q.size() != 0 || s_tvalid || freq_expect_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_rate(input logic [pifm_pkg::NUM_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        rate_num   = v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly well-formed captures with random content, some broken ones and noise
    task automatic random_phase(input int item_goal, input int cap_goal);
        int pushed;
        int caps;
        int kind;
        int period;
        int step;
        int base;
        int noise;
        int len;
        pushed = 0;
        caps   = 0;
        while (pushed < item_goal || caps < cap_goal) begin
            kind   = $urandom_range(0, 99);
            period = $urandom_range(2, 16);
            step   = $urandom_range(1, 4000 / (period / 2 + 1));
            noise  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            base   = $urandom_range(0, SAMPLE_MAX - (period / 2) * step - noise);
            if (kind < 55) begin
                // periodic capture, usually long enough for four peaks
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4 * period + 1)
                                                  : $urandom_range(4 * period + 2,
                                                                   4 * period + 12);
                push_wave(len, period, step, base, noise, 1'b1, 1'b1);
                caps++;
            end else if (kind < 70) begin
                // uniform noise capture
                len = $urandom_range(1, 30);
                for (int k = 0; k < len; k++)
                    push_item($urandom_range(0, SAMPLE_MAX), k == 0, k == len - 1);
                caps++;
            end else if (kind < 82) begin
                // few distinct levels, many plateaus
                len = $urandom_range(4, 30);
                for (int k = 0; k < len; k++)
                    push_item(base + $urandom_range(0, 2) * (step / 2), k == 0, k == len - 1);
                caps++;
            end else if (kind < 92) begin
                // wave without a capture start, continues whatever state is held
                len = $urandom_range(2, 40);
                push_wave(len, period, step, base, noise, 1'b0, $urandom_range(0, 1));
            end else if (kind < 97 || ramp_cnt >= 4) begin
                // stray item with random flags
                len = 1;
                push_item($urandom_range(0, SAMPLE_MAX), $urandom_range(0, 1),
                          $urandom_range(0, 1));
            end else begin
                // rising ramp past the memory end without a last flag
                len = RAMP_LEN;
                for (int k = 0; k < len; k++)
                    push_item(k * 15, k == 0, 1'b0);
                ramp_cnt++;
                caps++;
            end
            pushed += len;
        end
    endtask

    // Stimulus
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // samples before any capture start, full-scale alternation: span of six
        for (int k = 0; k < 9; k++)
            push_item((k % 2) ? SAMPLE_MAX : 0, 1'b0, 1'b0);
        // after the result the rest of the capture is ignored
        push_item(SAMPLE_MAX, 1'b0, 1'b1);
        // plateau is no peak; one real peak, then the capture ends
        push_item(5, 1'b1, 1'b0);
        push_item(9, 1'b0, 1'b0);
        push_item(9, 1'b0, 1'b0);
        push_item(3, 1'b0, 1'b0);
        push_item(7, 1'b0, 1'b0);
        push_item(2, 1'b0, 1'b1);
        // fourth peak confirmed on the last sample
        for (int k = 0; k < 9; k++)
            push_item((k % 2) ? 3 : 1, k == 0, k == 8);
        // capture of a single sample
        push_item(SAMPLE_MAX, 1'b1, 1'b1);
        wait_drained();

        // zero numerator still reports found
        write_rate('0);
        for (int k = 0; k < 9; k++)
            push_item((k % 2) ? 100 : 50, k == 0, 1'b0);
        wait_drained();

        write_rate({pifm_pkg::NUM_W{1'b1}});
        random_phase(PHASE_ITEMS, PHASE_CAPS);
        wait_drained();

        write_rate(pifm_pkg::NUM_W'(1));
        idle_on = 1'b0;
        random_phase(PHASE_ITEMS, PHASE_CAPS);
        wait_drained();

        write_rate(pifm_pkg::NUM_W'($urandom_range(1, (1 << pifm_pkg::NUM_W) - 1)));
        idle_on = 1'b1;
        random_phase(PHASE_ITEMS, PHASE_CAPS);
        wait_drained();

        // closing stretch at full rate on both sides
        write_rate(pifm_pkg::NUM_W'($urandom_range(1, (1 << pifm_pkg::NUM_W) - 1)));
        idle_on = 1'b0;
        random_phase(PHASE_ITEMS, PHASE_CAPS);
        wait_drained();

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pifm_pkg.sv
rtl/pifm_front.sv
rtl/pifm_queue.sv
rtl/pifm_back.sv
rtl/peak_interval_frequency_meter_top.sv
rtl/pifm_checker.sv
dv/tb_peak_interval_frequency_meter_top.sv
